/* hw/rtl/stt_pkg.sv */
// Package for the source text tokenizer: token kinds, scanner modes,
// character codes and the token record types shared by all modules.
// No dependencies.
package stt_pkg;

  // Token kinds as they appear on the token_kind output
  typedef enum logic [4:0] {
    KIND_END      = 5'd0,
    KIND_IDENT    = 5'd1,
    KIND_KEYWORD  = 5'd2,
    KIND_NUMBER   = 5'd3,
    KIND_STRING   = 5'd4,
    KIND_PLUS     = 5'd5,
    KIND_MINUS    = 5'd6,
    KIND_STAR     = 5'd7,
    KIND_SLASH    = 5'd8,
    KIND_LT       = 5'd9,
    KIND_LE       = 5'd10,
    KIND_GT       = 5'd11,
    KIND_GE       = 5'd12,
    KIND_ASSIGN   = 5'd13,
    KIND_EQ       = 5'd14,
    KIND_BANG     = 5'd15,
    KIND_NE       = 5'd16,
    KIND_COMMA    = 5'd17,
    KIND_LBRACE   = 5'd18,
    KIND_RBRACE   = 5'd19,
    KIND_LPAREN   = 5'd20,
    KIND_RPAREN   = 5'd21,
    KIND_NEWLINE  = 5'd22,
    KIND_RANGE    = 5'd23,
    KIND_INVALID  = 5'd24,
    KIND_UNTERM   = 5'd25
  } kind_e;

  // Scanner modes: what kind of token is open
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_IDENT  = 4'd1,
    MODE_NUM    = 4'd2,
    MODE_STR    = 4'd3,
    MODE_LT     = 4'd4,
    MODE_GT     = 4'd5,
    MODE_ASSIGN = 4'd6,
    MODE_BANG   = 4'd7,
    MODE_DOT    = 4'd8
  } mode_e;

  // Character codes
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // Field widths fixed by the interface
  localparam int unsigned KW_BITS       = 64;
  localparam int unsigned KW_INDEX_BITS = 3;
  localparam int unsigned VALUE_BITS    = 31;
  localparam int unsigned OUT_CNT_BITS  = 16;
  localparam logic [VALUE_BITS-1:0] NUM_MAX = 31'h7FFF_FFFF;

  // Token group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned GROUP_MAX   = 3;

  // One token as classified by the front; keyword lookup happens in the back
  typedef struct packed {
    kind_e                   kind;
    logic [VALUE_BITS-1:0]   value;
    logic                    ovf;
    logic [OUT_CNT_BITS-1:0] length;
    logic [OUT_CNT_BITS-1:0] line;
    logic [KW_BITS-1:0]      chars;   // identifier text, zero padded
    logic                    kw_ok;   // identifier short enough to be a keyword
  } tok_t;

  // All tokens caused by one input byte
  typedef struct packed {
    logic [1:0]           count;
    tok_t [GROUP_MAX-1:0] toks;
  } group_t;

endpackage

/* hw/rtl/stt_queue.sv */
// Short queue of token groups between the scanner front and the output back.
// Depends on stt_pkg (group_t, QUEUE_DEPTH).
module stt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::group_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output stt_pkg::group_t head_o,
  output logic            empty_o
);
  import stt_pkg::*;

  group_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;

  function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_BITS'(1);
  endfunction

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Front must stall while full; back pops only what is there
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("token queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("token queue popped while empty");

endmodule

/* hw/rtl/stt_front.sv */
// Scanner front: accepts one source byte per transfer, tracks the open token
// and pushes the group of tokens each byte completes. Depends on stt_pkg.
module stt_front #(
  parameter int unsigned KEYWORD_CHARS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      text_byte_i,
  input  logic            is_final_i,
  output logic            push_o,
  output stt_pkg::group_t push_data_o,
  input  logic            q_full_i
);
  import stt_pkg::*;

  localparam int unsigned CHAR_BITS = 8 * KEYWORD_CHARS;
  localparam logic [COUNT_BITS-1:0] KW_LIMIT = COUNT_BITS'(KEYWORD_CHARS);

  mode_e                 mode_q, mode_d;
  logic [CHAR_BITS-1:0]  ident_q, ident_d;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] line_q, line_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  sat_q, sat_d;
  logic                  dq_q, dq_d;

  logic                  accept;
  group_t                grp;
  logic [1:0]            n;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    if (c == '1) return c;
    return c + COUNT_BITS'(1);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
           (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic tok_t simple_tok(input kind_e k, input logic [COUNT_BITS-1:0] ln);
    tok_t t;
    t      = '0;
    t.kind = k;
    t.line = OUT_CNT_BITS'(ln);
    return t;
  endfunction

  // Token for whatever is open in mode m, used when that token is cut short
  function automatic tok_t open_tok(input mode_e m, input logic [CHAR_BITS-1:0] ch,
                                    input logic [COUNT_BITS-1:0] run,
                                    input logic [VALUE_BITS-1:0] acc, input logic sat,
                                    input logic [COUNT_BITS-1:0] ln);
    tok_t t;
    t = simple_tok(KIND_END, ln);
    unique case (m)
      MODE_IDENT: begin
        t.kind   = KIND_IDENT;
        t.length = OUT_CNT_BITS'(run);
        t.chars  = KW_BITS'(ch);
        t.kw_ok  = (run <= KW_LIMIT);
      end
      MODE_NUM: begin
        t.kind   = KIND_NUMBER;
        t.value  = acc;
        t.ovf    = sat;
        t.length = OUT_CNT_BITS'(run);
      end
      MODE_STR: begin
        t.kind   = KIND_UNTERM;
        t.length = OUT_CNT_BITS'(run);
      end
      MODE_LT:     t.kind = KIND_LT;
      MODE_GT:     t.kind = KIND_GT;
      MODE_ASSIGN: t.kind = KIND_ASSIGN;
      MODE_BANG:   t.kind = KIND_BANG;
      MODE_DOT:    t.kind = KIND_INVALID;
      default:     t.kind = KIND_END;
    endcase
    return t;
  endfunction

  // Two-character form of a waiting operator
  function automatic kind_e pair_kind(input mode_e m);
    unique case (m)
      MODE_LT:     return KIND_LE;
      MODE_GT:     return KIND_GE;
      MODE_ASSIGN: return KIND_EQ;
      default:     return KIND_NE;
    endcase
  endfunction

  // Single-character symbols; anything unknown is invalid
  function automatic kind_e sym_kind(input logic [7:0] b);
    unique case (b)
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_STAR;
      CH_SLASH:  return KIND_SLASH;
      CH_COMMA:  return KIND_COMMA;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      default:   return KIND_INVALID;
    endcase
  endfunction

  assign accept      = in_valid_i && !q_full_i;
  assign in_stall_o  = q_full_i;
  assign push_o      = accept && (n != 2'd0);
  assign push_data_o = grp;

  // Scanner step: continue the open token, or cut it and start a new one,
  // then close everything on end of text
  always_comb begin
    logic [VALUE_BITS+3:0] prod;
    logic                  restart;
    logic                  end_now;
    mode_d  = mode_q;
    ident_d = ident_q;
    run_d   = run_q;
    line_d  = line_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    dq_d    = dq_q;
    grp     = '0;
    n       = 2'd0;
    prod    = '0;
    restart = 1'b0;
    end_now = (text_byte_i == CH_NUL) || is_final_i;

    if (text_byte_i != CH_NUL) begin
      // continue the open token where the byte allows it
      unique case (mode_q)
        MODE_STR: begin
          if (text_byte_i == (dq_q ? CH_DQUOTE : CH_SQUOTE)) begin
            grp.toks[n]        = simple_tok(KIND_STRING, line_d);
            grp.toks[n].length = OUT_CNT_BITS'(run_q);
            n                  = n + 2'd1;
            mode_d             = MODE_IDLE;
            ident_d            = '0;
            run_d              = '0;
            acc_d              = '0;
            sat_d              = 1'b0;
          end else begin
            run_d = bump(run_q);
          end
        end
        MODE_IDENT: begin
          if (is_letter(text_byte_i)) begin
            if (run_q < KW_LIMIT) begin
              for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (run_q == COUNT_BITS'(i)) ident_d[8*i +: 8] = text_byte_i;
              end
            end
            run_d = bump(run_q);
          end else begin
            restart = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(text_byte_i)) begin
            // acc * 10 + digit, saturating at the 31-bit maximum
            prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                   (VALUE_BITS+4)'(text_byte_i - CH_ZERO);
            if (prod > {4'b0, NUM_MAX}) begin
              acc_d = NUM_MAX;
              sat_d = 1'b1;
            end else begin
              acc_d = prod[VALUE_BITS-1:0];
            end
            run_d = bump(run_q);
          end else begin
            restart = 1'b1;
          end
        end
        MODE_LT, MODE_GT, MODE_ASSIGN, MODE_BANG: begin
          if (text_byte_i == CH_EQUAL) begin
            grp.toks[n] = simple_tok(pair_kind(mode_q), line_d);
            n           = n + 2'd1;
            mode_d      = MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_DOT: begin
          if (text_byte_i == CH_DOT) begin
            grp.toks[n] = simple_tok(KIND_RANGE, line_d);
            n           = n + 2'd1;
            mode_d      = MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        // close the open token
        if (mode_q != MODE_IDLE) begin
          grp.toks[n] = open_tok(mode_q, ident_q, run_q, acc_q, sat_q, line_d);
          n           = n + 2'd1;
        end
        mode_d  = MODE_IDLE;
        ident_d = '0;
        run_d   = '0;
        acc_d   = '0;
        sat_d   = 1'b0;
        // classify the byte as the start of a new token
        priority if (is_letter(text_byte_i)) begin
          mode_d        = MODE_IDENT;
          ident_d[7:0]  = text_byte_i;
          run_d         = COUNT_BITS'(1);
        end else if (is_digit(text_byte_i)) begin
          mode_d = MODE_NUM;
          acc_d  = VALUE_BITS'(text_byte_i - CH_ZERO);
          run_d  = COUNT_BITS'(1);
        end else if (text_byte_i == CH_SPACE || text_byte_i == CH_TAB ||
                     text_byte_i == CH_CR) begin
          mode_d = MODE_IDLE;
        end else if (text_byte_i == CH_LF) begin
          grp.toks[n] = simple_tok(KIND_NEWLINE, line_d);
          n           = n + 2'd1;
          line_d      = bump(line_q);
        end else if (text_byte_i == CH_DQUOTE || text_byte_i == CH_SQUOTE) begin
          mode_d = MODE_STR;
          dq_d   = (text_byte_i == CH_DQUOTE);
        end else if (text_byte_i == CH_LT) begin
          mode_d = MODE_LT;
        end else if (text_byte_i == CH_GT) begin
          mode_d = MODE_GT;
        end else if (text_byte_i == CH_EQUAL) begin
          mode_d = MODE_ASSIGN;
        end else if (text_byte_i == CH_BANG) begin
          mode_d = MODE_BANG;
        end else if (text_byte_i == CH_DOT) begin
          mode_d = MODE_DOT;
        end else begin
          grp.toks[n] = simple_tok(sym_kind(text_byte_i), line_d);
          n           = n + 2'd1;
        end
      end
    end

    // end of text: close what is open, send the end token, clear state
    if (end_now) begin
      if (mode_d != MODE_IDLE) begin
        grp.toks[n] = open_tok(mode_d, ident_d, run_d, acc_d, sat_d, line_d);
        n           = n + 2'd1;
      end
      grp.toks[n] = simple_tok(KIND_END, line_d);
      n           = n + 2'd1;
      mode_d      = MODE_IDLE;
      ident_d     = '0;
      run_d       = '0;
      acc_d       = '0;
      sat_d       = 1'b0;
      dq_d        = 1'b0;
      line_d      = '0;
    end
    grp.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ident_q <= '0;
      run_q   <= '0;
      line_q  <= '0;
      acc_q   <= '0;
      sat_q   <= 1'b0;
      dq_q    <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      ident_q <= ident_d;
      run_q   <= run_d;
      line_q  <= line_d;
      acc_q   <= acc_d;
      sat_q   <= sat_d;
      dq_q    <= dq_d;
    end
  end

  // End of text always leaves the scanner idle on line zero
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((text_byte_i == CH_NUL) || is_final_i)) |=>
      (mode_q == MODE_IDLE) && (line_q == '0) && (run_q == '0))
    else $error("scanner state not cleared after end of text");

  // Every byte that ends the text pushes a group
  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((text_byte_i == CH_NUL) || is_final_i)) |-> push_o)
    else $error("end of text produced no tokens");

endmodule

/* hw/rtl/stt_back.sv */
// Output back: holds the keyword registers, steps through each queued token
// group one token per transfer and resolves keywords. Depends on stt_pkg.
module stt_back #(
  parameter int unsigned KEYWORD_SLOTS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_valid_i,
  input  logic [stt_pkg::KW_INDEX_BITS-1:0]      cfg_index_i,
  input  logic [stt_pkg::KW_BITS-1:0]            cfg_data_i,
  // queue head
  input  stt_pkg::group_t                        head_i,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  // token output
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [4:0]                             token_kind_o,
  output logic [stt_pkg::KW_INDEX_BITS-1:0]      keyword_index_o,
  output logic [stt_pkg::VALUE_BITS-1:0]         number_value_o,
  output logic                                   number_overflow_o,
  output logic [stt_pkg::OUT_CNT_BITS-1:0]       token_length_o,
  output logic [stt_pkg::OUT_CNT_BITS-1:0]       line_number_o,
  output logic                                   last_of_run_o
);
  import stt_pkg::*;

  logic [KW_BITS-1:0]       kw_q [KEYWORD_SLOTS];
  logic [1:0]               idx_q, idx_d;
  logic                     load;
  logic                     last;
  tok_t                     cur;
  logic                     hit;
  logic [KW_INDEX_BITS-1:0] hit_idx;
  kind_e                    kind;

  logic                     valid_q;
  kind_e                    kind_q;
  logic [KW_INDEX_BITS-1:0] kwi_q;
  logic [VALUE_BITS-1:0]    value_q;
  logic                     ovf_q;
  logic [OUT_CNT_BITS-1:0]  len_q;
  logic [OUT_CNT_BITS-1:0]  line_q;
  logic                     last_q;

  // Keyword registers; writes beyond the populated slots are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) kw_q[i] <= '0;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) begin
        if (cfg_index_i == KW_INDEX_BITS'(i)) kw_q[i] <= cfg_data_i;
      end
    end
  end

  // Pick the next token from the head group
  assign cur   = head_i.toks[idx_q];
  assign last  = (idx_q == (head_i.count - 2'd1));
  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  // Keyword lookup, lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
      if (kw_q[i] != '0 && kw_q[i] == cur.chars) begin
        hit     = 1'b1;
        hit_idx = KW_INDEX_BITS'(i);
      end
    end
    kind = cur.kind;
    if (cur.kind == KIND_IDENT && cur.kw_ok && hit) kind = KIND_KEYWORD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind;
      kwi_q   <= (kind == KIND_KEYWORD) ? hit_idx : '0;
      value_q <= cur.value;
      ovf_q   <= cur.ovf;
      len_q   <= cur.length;
      line_q  <= cur.line;
      last_q  <= last;
    end
  end

  assign out_valid_o       = valid_q;
  assign token_kind_o      = kind_q;
  assign keyword_index_o   = kwi_q;
  assign number_value_o    = value_q;
  assign number_overflow_o = ovf_q;
  assign token_length_o    = len_q;
  assign line_number_o     = line_q;
  assign last_of_run_o     = last_q;

  // The token index never runs past the group it walks
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.count))
    else $error("token index beyond group size");

endmodule

/* hw/rtl/source_text_tokenizer.sv */
// Source text tokenizer top level: scanner front, token group queue, output back.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
// A token passes through the group queue and then the output register after its byte is taken.
// Throughput: one byte per cycle unless the queue is full; one token per cycle out
// unless stalled, so bytes that complete two or three tokens hold the output for one transfer per token.
// Reset clears all scanner state and keyword registers; no clearing pass.
module source_text_tokenizer #(
  parameter int unsigned KEYWORD_SLOTS = 8,
  parameter int unsigned KEYWORD_CHARS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // byte input
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [7:0]                             text_byte_i,
  input  logic                                   is_final_i,
  // token output
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [4:0]                             token_kind_o,
  output logic [stt_pkg::KW_INDEX_BITS-1:0]      keyword_index_o,
  output logic [stt_pkg::VALUE_BITS-1:0]         number_value_o,
  output logic                                   number_overflow_o,
  output logic [stt_pkg::OUT_CNT_BITS-1:0]       token_length_o,
  output logic [stt_pkg::OUT_CNT_BITS-1:0]       line_number_o,
  output logic                                   last_of_run_o,
  // keyword register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [stt_pkg::KW_INDEX_BITS-1:0]      cfg_index_i,
  input  logic [stt_pkg::KW_BITS-1:0]            cfg_data_i
);
  import stt_pkg::*;

  logic   push;
  group_t push_data;
  logic   q_full;
  logic   pop;
  group_t head;
  logic   q_empty;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  stt_front #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .is_final_i  (is_final_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  stt_back #(
    .KEYWORD_SLOTS (KEYWORD_SLOTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .head_i            (head),
    .empty_i           (q_empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .token_kind_o      (token_kind_o),
    .keyword_index_o   (keyword_index_o),
    .number_value_o    (number_value_o),
    .number_overflow_o (number_overflow_o),
    .token_length_o    (token_length_o),
    .line_number_o     (line_number_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule
